/* src/ubd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubd_pkg
// Shared widths, register indexes, reset values and pipeline payload types
// for the UART baud divisor select block.
// ----------------------------------------------------------------------------
package ubd_pkg;

   // field widths
   localparam int TICK_W = 32;
   localparam int TOL_W  = 10;
   localparam int BAUD_W = 24;
   localparam int DIV_W  = 16;
   localparam int CSR_W  = 32;
   localparam int IDX_W  = 2;

   // quotient bits of the two divisions: divisor try, then error ratio
   localparam int QUO1_W = 17;
   localparam int QUO2_W = 12;

   // 2000 * tick, remainder and denominator (divisor * baud) widths
   localparam int T2K_W = 43;
   localparam int REM_W = 44;
   localparam int DEN_W = 40;

   // register indexes
   localparam logic [IDX_W-1:0] CSR_TICK_RATE = 2'd0;
   localparam logic [IDX_W-1:0] CSR_ERR_TOL   = 2'd1;
   localparam logic [IDX_W-1:0] CSR_PRESCALE  = 2'd2;

   // reset values
   localparam logic [TICK_W-1:0] TICK_RESET = 32'd115200;
   localparam logic [TOL_W-1:0]  TOL_RESET  = 10'd20;

   // error ratio constants: unity in per mille, doubled scale for rounding
   localparam logic [QUO2_W-1:0] PPM_UNITY = 12'd1000;
   localparam logic [10:0]       ERR_SCALE = 11'd2000;

   // largest first quotient that still rounds to a 16-bit divisor, plus one
   localparam logic [QUO1_W-1:0] QUO1_LIMIT = 17'h1ffff;

   typedef struct packed {
      logic [T2K_W-1:0]  t2k;   // 2000 * tick of this lane
      logic [REM_W-1:0]  rem;   // running remainder
      logic [DEN_W-1:0]  den;   // running denominator
      logic [QUO1_W-1:0] quo;   // quotient bits so far
      logic [DIV_W-1:0]  dv;    // candidate divisor
      logic              ok;    // candidate still usable
   } lane_type;

   // lane 0 uses tick, lane 1 uses tick / 4
   typedef struct packed {
      lane_type [1:0]    lane;
      logic [BAUD_W-1:0] baud;
   } stage_type;

   typedef struct packed {
      logic [DIV_W-1:0] divisor;
      logic             use_div4;
      logic             failed;
   } result_type;

endpackage

/* src/uart_baud_divisor_select_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_baud_divisor_select_core
// Picks a 16-bit UART divisor for a requested baud rate within a per mille
// error tolerance, optionally through the divide-by-four prescaler.
// ----------------------------------------------------------------------------
// Usage:
//   A request carries req_baud_rate on req_valid/req_ready. Each request gives
//   exactly one response on rsp_valid/rsp_ready: rsp_divisor, rsp_use_div4
//   and rsp_failed, in request order.
//   Registers tick_rate, error_tolerance and prescale_allowed are written
//   through csr_write_en/csr_index/csr_write_data; the user must do so only
//   while no request is in flight, as the block does not enforce it. An
//   index beyond the list is ignored. The chain has one entry cell, 17
//   divisor quotient cells, one multiply cell, 12 error ratio cells and the
//   response register, and takes one request per cycle while the receiver
//   keeps up; the direct and the prescaled try run side by side in every
//   cell. When the receiver stalls, the response register holds and the
//   chain keeps filling its empty cells; req_ready drops once all are full.
//   Reset empties the chain and loads the register reset values.
// ----------------------------------------------------------------------------
module uart_baud_divisor_select_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [ubd_pkg::BAUD_W-1:0]  req_baud_rate,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ubd_pkg::DIV_W-1:0]   rsp_divisor,
   output logic                        rsp_use_div4,
   output logic                        rsp_failed,
   input  logic                        csr_write_en,
   input  logic [ubd_pkg::IDX_W-1:0]   csr_index,
   input  logic [ubd_pkg::CSR_W-1:0]   csr_write_data
);

   localparam int N1   = ubd_pkg::QUO1_W;
   localparam int N2   = ubd_pkg::QUO2_W;
   localparam int LAST = N1 + 1 + N2;

   logic [ubd_pkg::TICK_W-1:0] tick_ff;
   logic [ubd_pkg::TOL_W-1:0]  tol_ff;
   logic                       prescale_ff;

   logic                       entry_valid_ff;
   ubd_pkg::stage_type         entry_ff;
   ubd_pkg::stage_type         entry_in;
   logic [ubd_pkg::TICK_W-1:0] lane_tick [2];

   ubd_pkg::stage_type         st  [LAST+1];
   logic                       vld [LAST+1];
   logic                       rdy [LAST+1];
   ubd_pkg::result_type        rsp;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff     <= ubd_pkg::TICK_RESET;
         tol_ff      <= ubd_pkg::TOL_RESET;
         prescale_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            ubd_pkg::CSR_TICK_RATE: tick_ff     <= csr_write_data[ubd_pkg::TICK_W-1:0];
            ubd_pkg::CSR_ERR_TOL:   tol_ff      <= csr_write_data[ubd_pkg::TOL_W-1:0];
            ubd_pkg::CSR_PRESCALE:  prescale_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // entry cell: set up both tries, reject zero baud and oversized quotient
   always_comb begin
      lane_tick[0] = tick_ff;
      lane_tick[1] = tick_ff >> 2;
      entry_in.baud = req_baud_rate;
      for (int l = 0; l < 2; l++) begin
         entry_in.lane[l].t2k = ubd_pkg::T2K_W'(lane_tick[l]) *
                                ubd_pkg::T2K_W'(ubd_pkg::ERR_SCALE);
         entry_in.lane[l].rem = ubd_pkg::REM_W'({lane_tick[l], 1'b0});
         entry_in.lane[l].den = ubd_pkg::DEN_W'(req_baud_rate);
         entry_in.lane[l].quo = '0;
         entry_in.lane[l].dv  = '0;
         entry_in.lane[l].ok  = (req_baud_rate != '0) &&
                                (ubd_pkg::BAUD_W'({lane_tick[l], 1'b0} >> N1) <
                                 req_baud_rate);
      end
   end

   assign req_ready = !entry_valid_ff || rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (req_ready) begin
         entry_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         entry_ff <= entry_in;
      end
   end

   assign st[0]  = entry_ff;
   assign vld[0] = entry_valid_ff;

   // divisor quotient cells, most significant bit first
   for (genvar i = 0; i < N1; i++) begin : g_quo1
      ubd_div_cell #(.BIT(N1 - 1 - i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld[i]),
         .in_data   (st[i]),
         .in_ready  (rdy[i]),
         .out_valid (vld[i+1]),
         .out_data  (st[i+1]),
         .out_ready (rdy[i+1])
      );
   end

   // divisor rounding and denominator product
   ubd_mul_cell u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld[N1]),
      .in_data   (st[N1]),
      .in_ready  (rdy[N1]),
      .out_valid (vld[N1+1]),
      .out_data  (st[N1+1]),
      .out_ready (rdy[N1+1])
   );

   // error ratio quotient cells
   for (genvar j = 0; j < N2; j++) begin : g_quo2
      ubd_div_cell #(.BIT(N2 - 1 - j)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld[N1+1+j]),
         .in_data   (st[N1+1+j]),
         .in_ready  (rdy[N1+1+j]),
         .out_valid (vld[N1+2+j]),
         .out_data  (st[N1+2+j]),
         .out_ready (rdy[N1+2+j])
      );
   end

   // tolerance check, selection and response register
   ubd_pick_cell u_pick (
      .clock     (clock),
      .reset     (reset),
      .tolerance (tol_ff),
      .prescale  (prescale_ff),
      .in_valid  (vld[LAST]),
      .in_data   (st[LAST]),
      .in_ready  (rdy[LAST]),
      .out_valid (rsp_valid),
      .out_data  (rsp),
      .out_ready (rsp_ready)
   );

   assign rsp_divisor  = rsp.divisor;
   assign rsp_use_div4 = rsp.use_div4;
   assign rsp_failed   = rsp.failed;

   // a failed response carries no divisor and no prescaler choice
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_failed |-> rsp_divisor == '0 && !rsp_use_div4)
      else $error("failed response with nonzero divisor or prescaler");

   // a good response never has a zero divisor
   a_pass_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_failed |-> rsp_divisor != '0)
      else $error("good response with zero divisor");

   // the prescaler is reported only when it is allowed
   a_div4_allowed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_use_div4 |-> prescale_ff)
      else $error("prescaler used while not allowed");

   // nothing comes out of the chain right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

/* src/ubd_div_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubd_div_cell
// One restoring division step for both lanes: decides quotient bit BIT and
// hands the updated remainder to the next cell.
// ----------------------------------------------------------------------------
module ubd_div_cell #(
   parameter int BIT = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  ubd_pkg::stage_type in_data,
   output logic               in_ready,
   output logic               out_valid,
   output ubd_pkg::stage_type out_data,
   input  logic               out_ready
);

   logic               valid_ff;
   ubd_pkg::stage_type data_ff;
   ubd_pkg::stage_type data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // compare the shifted remainder against the denominator, subtract on hit
   always_comb begin
      data_in = in_data;
      for (int l = 0; l < 2; l++) begin
         if ((in_data.lane[l].rem >> BIT) >= ubd_pkg::REM_W'(in_data.lane[l].den)) begin
            data_in.lane[l].rem = in_data.lane[l].rem -
                                  (ubd_pkg::REM_W'(in_data.lane[l].den) << BIT);
            data_in.lane[l].quo[BIT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

/* src/ubd_mul_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubd_mul_cell
// Rounds the first quotient to a divisor, range checks it and forms
// divisor * baud as the denominator of the error ratio division.
// ----------------------------------------------------------------------------
module ubd_mul_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  ubd_pkg::stage_type in_data,
   output logic               in_ready,
   output logic               out_valid,
   output ubd_pkg::stage_type out_data,
   input  logic               out_ready
);

   logic                         valid_ff;
   ubd_pkg::stage_type           data_ff;
   ubd_pkg::stage_type           data_in;
   logic [ubd_pkg::QUO1_W:0]     rounded [2];

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      data_in = in_data;
      for (int l = 0; l < 2; l++) begin
         // round to nearest: (2t/b + 1) / 2
         rounded[l] = ({1'b0, in_data.lane[l].quo} + 1'b1) >> 1;
         data_in.lane[l].dv  = rounded[l][ubd_pkg::DIV_W-1:0];
         data_in.lane[l].ok  = in_data.lane[l].ok &&
                               (in_data.lane[l].quo != '0) &&
                               (in_data.lane[l].quo < ubd_pkg::QUO1_LIMIT);
         data_in.lane[l].den =
            ubd_pkg::DEN_W'(rounded[l][ubd_pkg::DIV_W-1:0]) *
            ubd_pkg::DEN_W'(in_data.baud);
         data_in.lane[l].rem = ubd_pkg::REM_W'(in_data.lane[l].t2k);
         data_in.lane[l].quo = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

/* src/ubd_pick_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubd_pick_cell
// Rounds the error ratio, checks it against the tolerance and picks the
// direct or prescaled divisor. Holds the response register.
// ----------------------------------------------------------------------------
module ubd_pick_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [ubd_pkg::TOL_W-1:0]  tolerance,
   input  logic                       prescale,
   input  logic                       in_valid,
   input  ubd_pkg::stage_type         in_data,
   output logic                       in_ready,
   output logic                       out_valid,
   output ubd_pkg::result_type        out_data,
   input  logic                       out_ready
);

   logic                        valid_ff;
   ubd_pkg::result_type         data_ff;
   ubd_pkg::result_type         data_in;
   logic [ubd_pkg::QUO2_W:0]    ratio [2];
   logic [ubd_pkg::QUO2_W-1:0]  err   [2];
   logic [1:0]                  pass;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         ratio[l] = ({1'b0, in_data.lane[l].quo[ubd_pkg::QUO2_W-1:0]} + 1'b1) >> 1;
         if (ratio[l][ubd_pkg::QUO2_W-1:0] >= ubd_pkg::PPM_UNITY) begin
            err[l] = ratio[l][ubd_pkg::QUO2_W-1:0] - ubd_pkg::PPM_UNITY;
         end else begin
            err[l] = ubd_pkg::PPM_UNITY - ratio[l][ubd_pkg::QUO2_W-1:0];
         end
         pass[l] = in_data.lane[l].ok &&
                   (err[l] <= ubd_pkg::QUO2_W'(tolerance));
      end

      // direct tick first, prescaled tick as fallback when it is allowed
      data_in = '{divisor: '0, use_div4: 1'b0, failed: 1'b1};
      if (pass[0]) begin
         data_in = '{divisor: in_data.lane[0].dv, use_div4: 1'b0, failed: 1'b0};
      end else if (prescale && pass[1]) begin
         data_in = '{divisor: in_data.lane[1].dv, use_div4: 1'b1, failed: 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

/* tb/uart_baud_divisor_select_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_baud_divisor_select_core_tb
// Sends baud rate requests through the divisor select core under several
// register settings and checks every response against a local calculation
// of the rounded divisor, the per mille error and the prescaler retry.
// ----------------------------------------------------------------------------
module uart_baud_divisor_select_core_tb;

   localparam int LATENCY   = 32;
   localparam int WDOG_MAX  = 20000;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [ubd_pkg::BAUD_W-1:0]   req_baud_rate = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [ubd_pkg::DIV_W-1:0]    rsp_divisor;
   logic                         rsp_use_div4;
   logic                         rsp_failed;
   logic                         csr_write_en = 1'b0;
   logic [ubd_pkg::IDX_W-1:0]    csr_index = '0;
   logic [ubd_pkg::CSR_W-1:0]    csr_write_data = '0;

   // local copy of the registers
   logic [ubd_pkg::TICK_W-1:0]   cur_tick;
   logic [ubd_pkg::TOL_W-1:0]    cur_tol;
   logic                         cur_prescale;

   ubd_pkg::result_type          pending_divisors[$];
   int                           err_count = 0;
   int                           idle_cycles = 0;
   bit                           rsp_stall_on = 1'b1;

   uart_baud_divisor_select_core u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog on accepted handshakes
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WDOG_MAX) begin
            $display("uart_baud_divisor_select_core_tb: FAIL");
            $finish;
         end
      end
   end

   // one try of the rounded divisor, 0 when unusable
   function automatic logic [63:0] try_divisor(logic [63:0] tick, logic [63:0] baud);
      logic [63:0] dv, den, q, err;
      if (baud == 0) return 0;
      dv = (tick * 2 / baud + 1) / 2;
      if (dv == 0 || dv > 64'hffff) return 0;
      den = dv * baud;
      q = (64'd1000 * tick * 2 / den + 1) / 2;
      err = (q >= 1000) ? q - 1000 : 1000 - q;
      if (err > cur_tol) return 0;
      return dv;
   endfunction

   function automatic ubd_pkg::result_type calc_divisor(logic [ubd_pkg::BAUD_W-1:0] baud);
      ubd_pkg::result_type r;
      logic [63:0] dv;
      dv = 0;
      r.use_div4 = 1'b0;
      if (baud != 0) begin
         dv = try_divisor(cur_tick, baud);
         if (dv == 0 && cur_prescale) begin
            dv = try_divisor(cur_tick / 4, baud);
            r.use_div4 = (dv != 0);
         end
      end
      r.divisor = dv[ubd_pkg::DIV_W-1:0];
      r.failed  = (dv == 0);
      return r;
   endfunction

   function automatic int rand_gap();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
      return $urandom_range(0, 3);
   endfunction

   // response side: random stall and compare
   always @(posedge clock) begin
      ubd_pkg::result_type exp_r;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_divisors.size() == 0) begin
               $error("response with no request waiting");
               err_count++;
            end else begin
               exp_r = pending_divisors.pop_front();
               if (rsp_divisor !== exp_r.divisor) begin
                  $error("divisor exp %0d got %0d", exp_r.divisor, rsp_divisor);
                  err_count++;
               end
               if (rsp_use_div4 !== exp_r.use_div4) begin
                  $error("use_div4 exp %0d got %0d", exp_r.use_div4, rsp_use_div4);
                  err_count++;
               end
               if (rsp_failed !== exp_r.failed) begin
                  $error("failed exp %0d got %0d", exp_r.failed, rsp_failed);
                  err_count++;
               end
            end
         end
         rsp_ready <= rsp_stall_on ? (rand_gap() == 0) : 1'b1;
      end
   end

   // valid drops only ahead of a gap, so back to back requests keep it high
   task automatic send_request(logic [ubd_pkg::BAUD_W-1:0] baud, bit gaps);
      int g;
      g = gaps ? rand_gap() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_baud_rate <= baud;
      do @(posedge clock); while (!req_ready);
      pending_divisors.push_back(calc_divisor(baud));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_divisors.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // register write followed by idle, with the local copy of the registers updated
   task automatic write_csr(logic [ubd_pkg::IDX_W-1:0] idx, logic [ubd_pkg::CSR_W-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         ubd_pkg::CSR_TICK_RATE: cur_tick     = data;
         ubd_pkg::CSR_ERR_TOL:   cur_tol      = data[ubd_pkg::TOL_W-1:0];
         ubd_pkg::CSR_PRESCALE:  cur_prescale = data[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // random baud, or one near tick / n or (tick / 4) / n, exercising both exact and off-ratio rates
   function automatic logic [ubd_pkg::BAUD_W-1:0] rand_baud();
      logic [63:0] b;
      int n;
      case ($urandom_range(0, 5))
         0: b = $urandom_range(0, 24'hffffff);
         1: b = $urandom_range(0, 255);
         2: b = {$urandom} & 24'hffffff;
         default: begin
            n = $urandom_range(1, 70000);
            if ($urandom_range(0, 1)) b = (cur_tick / 4) / n; else b = cur_tick / n;
            b = b + $urandom_range(0, 8) - 4;
         end
      endcase
      return b[ubd_pkg::BAUD_W-1:0];
   endfunction

   task automatic test_directed();
      logic [ubd_pkg::BAUD_W-1:0] list[$];
      list = '{24'd0, 24'd1, 24'hffffff, 24'd9600, 24'd115200, 24'd57600, 24'd300,
               24'd2, 24'd110, 24'd38400, 24'd28800, 24'd230400, 24'h800000,
               24'h555555, 24'haaaaaa};
      foreach (list[i]) send_request(list[i], 1'b0);
      drain();
      write_csr(ubd_pkg::CSR_PRESCALE, 32'd1);
      write_csr(ubd_pkg::CSR_TICK_RATE, 32'd1843200);
      foreach (list[i]) send_request(list[i], 1'b0);
      drain();
   endtask

   task automatic test_tick_extremes();
      write_csr(ubd_pkg::CSR_TICK_RATE, 32'd0);
      send_request(24'd1, 1'b1);
      send_request(24'd9600, 1'b1);
      drain();
      write_csr(ubd_pkg::CSR_TICK_RATE, 32'd3);
      send_request(24'd1, 1'b1);
      send_request(24'd3, 1'b1);
      drain();
      write_csr(ubd_pkg::CSR_TICK_RATE, 32'hffffffff);
      write_csr(ubd_pkg::CSR_ERR_TOL, 32'd1023);
      write_csr(2'd3, 32'hffffffff);   // out of range, ignored
      send_request(24'd1, 1'b1);
      send_request(24'hffffff, 1'b1);
      send_request(24'd65536, 1'b1);
      drain();
   endtask

   task automatic test_random_phase(logic [31:0] tick, logic [9:0] tol, bit pre, int n);
      write_csr(ubd_pkg::CSR_TICK_RATE, tick);
      write_csr(ubd_pkg::CSR_ERR_TOL, {22'd0, tol});
      write_csr(ubd_pkg::CSR_PRESCALE, {31'd0, pre});
      rsp_stall_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < n; i++) send_request(rand_baud(), rsp_stall_on);
      drain();
   endtask

   initial begin
      cur_tick     = ubd_pkg::TICK_RESET;
      cur_tol      = ubd_pkg::TOL_RESET;
      cur_prescale = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_tick_extremes();
      test_random_phase(32'd1843200, 10'd20, 1'b1, 120);
      test_random_phase(32'd115200, 10'd0, 1'b0, 100);
      test_random_phase(32'hffffffff, 10'd1000, 1'b1, 100);
      test_random_phase(32'd1, 10'd5, 1'b1, 60);
      test_random_phase($urandom, $urandom_range(0, 1023), 1'b1, 120);
      test_random_phase($urandom, $urandom_range(0, 50), 1'b0, 110);
      test_random_phase($urandom_range(1000, 100000000), $urandom_range(0, 100),
                        1'b1, 120);
      test_random_phase(32'd48000000, 10'd30, 1'b1, 80);
      if (err_count == 0)
         $display("uart_baud_divisor_select_core_tb: PASS");
      else
         $display("uart_baud_divisor_select_core_tb: FAIL");
      $finish;
   end

endmodule

/* uart_baud_divisor_select_core.f */
src/ubd_pkg.sv
src/ubd_div_cell.sv
src/ubd_mul_cell.sv
src/ubd_pick_cell.sv
src/uart_baud_divisor_select_core.sv
tb/uart_baud_divisor_select_core_tb.sv
